FILE: rtl/core/bbf_pkg.sv
`timescale 1ns / 1ps

package bbf_pkg;

    // transport packet and frame geometry
    localparam int PACKET_BYTES        = 188;
    localparam int MAX_FIELD_BYTES_DEF = 7264;
    localparam int MIN_KBCH            = 3072;
    localparam int HDR_BYTES           = 10;

    // header constants
    localparam logic [7:0]  SYNC_BYTE = 8'h47;
    localparam logic [7:0]  PAD_BYTE  = 8'hB8;
    localparam logic [7:0]  CRC_POLY  = 8'hD5;
    localparam logic [15:0] UPL_BITS  = 16'(PACKET_BYTES * 8);
    localparam logic [1:0]  MATYPE_TS = 2'b11;

    // header byte positions
    localparam logic [3:0] HDR_MATYPE1 = 4'd0;
    localparam logic [3:0] HDR_MATYPE2 = 4'd1;
    localparam logic [3:0] HDR_UPL_HI  = 4'd2;
    localparam logic [3:0] HDR_UPL_LO  = 4'd3;
    localparam logic [3:0] HDR_DFL_HI  = 4'd4;
    localparam logic [3:0] HDR_DFL_LO  = 4'd5;
    localparam logic [3:0] HDR_SYNC    = 4'd6;
    localparam logic [3:0] HDR_SYNCD_H = 4'd7;
    localparam logic [3:0] HDR_SYNCD_L = 4'd8;
    localparam logic [3:0] HDR_CRC     = 4'd9;
    localparam logic [3:0] HDR_DONE    = 4'(HDR_BYTES);

    // byte kinds on the output
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_PAD  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_BITS = 2'd0;
    localparam logic [1:0] REG_ADAPTIVE   = 2'd1;
    localparam logic [1:0] REG_ROLL_OFF   = 2'd2;
    localparam logic [1:0] REG_STREAM_ID  = 2'd3;

    // roll-off codes
    localparam logic [1:0] RO_35    = 2'd0;
    localparam logic [1:0] RO_25    = 2'd1;
    localparam logic [1:0] RO_OTHER = 2'd2;

    // exact floor(f / 188) for f below 2**14 by reciprocal multiply
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 15;
    localparam int RECIP       = (2 ** RECIP_SHIFT) / PACKET_BYTES + 1;

    // cycles the derived frame values need after a register write
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

    // header settings seen by the back end
    typedef struct packed {
        logic        adaptive;
        logic [1:0]  ro_code;
        logic [7:0]  stream_id;
        logic [15:0] dfl;
    } hdr_cfg_t;

    // one classified input beat
    typedef struct packed {
        logic       hdr;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } entry_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/bbf_cfg.sv
`timescale 1ns / 1ps

module bbf_cfg
    import bbf_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF,
    parameter int FB_W            = $clog2(MAX_FIELD_BYTES + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output logic            busy,
    output logic [FB_W-1:0] field_bytes,
    output logic [FB_W-1:0] whole_bytes,
    output hdr_cfg_t        hdr_cfg
);

    localparam int Q_W      = $clog2(MAX_FIELD_BYTES / PACKET_BYTES + 1);
    localparam int KB_W     = 15;
    localparam int P_W      = FB_W + RECIP_W;
    localparam int KB_MIN   = MIN_KBCH / 8;
    localparam int KB_MAX   = MAX_FIELD_BYTES + HDR_BYTES;

    logic [15:0]     frame_bits_reg;
    logic            adaptive_reg;
    logic [6:0]      roll_off_reg;
    logic [7:0]      stream_id_reg;
    logic [2:0]      settle_reg;
    logic [FB_W-1:0] field_reg;
    logic [Q_W-1:0]  quot_reg;
    logic [FB_W-1:0] whole_reg;

    logic [KB_W-1:0] kb;
    logic [KB_W-1:0] kb_clamp;
    logic [FB_W-1:0] field_next;
    logic [P_W-1:0]  prod;
    logic [Q_W-1:0]  quot_next;
    logic [FB_W-1:0] whole_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits_reg <= 16'd58192;
            adaptive_reg   <= 1'b1;
            roll_off_reg   <= 7'd20;
            stream_id_reg  <= 8'd0;
            settle_reg     <= SETTLE_CYCLES;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                settle_reg <= SETTLE_CYCLES;
                unique case (cfg_index)
                    REG_FRAME_BITS: frame_bits_reg <= cfg_data;
                    REG_ADAPTIVE:   adaptive_reg   <= cfg_data[0];
                    REG_ROLL_OFF:   roll_off_reg   <= cfg_data[6:0];
                    REG_STREAM_ID:  stream_id_reg  <= cfg_data[7:0];
                    default:        settle_reg     <= SETTLE_CYCLES;
                endcase
            end
            else if (settle_reg != 3'd0)
            begin
                settle_reg <= settle_reg - 3'd1;
            end
        end
    end

    // low three bits ignored, length clamped to the legal range
    always_comb
    begin
        kb = KB_W'(frame_bits_reg[15:3]);
        if (kb < KB_W'(KB_MIN))
        begin
            kb_clamp = KB_W'(KB_MIN);
        end
        else if (kb > KB_W'(KB_MAX))
        begin
            kb_clamp = KB_W'(KB_MAX);
        end
        else
        begin
            kb_clamp = kb;
        end
        field_next = FB_W'(kb_clamp - KB_W'(HDR_BYTES));
        prod       = P_W'(field_reg) * P_W'(RECIP);
        quot_next  = Q_W'(prod >> RECIP_SHIFT);
        whole_next = FB_W'(quot_reg) * FB_W'(PACKET_BYTES);
    end

    always_ff @(posedge clk)
    begin
        field_reg <= field_next;
        quot_reg  <= quot_next;
        whole_reg <= whole_next;
    end

    assign busy        = (settle_reg != 3'd0);
    assign field_bytes = field_reg;
    assign whole_bytes = whole_reg;

    always_comb
    begin
        hdr_cfg.adaptive  = adaptive_reg;
        hdr_cfg.stream_id = stream_id_reg;
        hdr_cfg.dfl       = 16'({field_reg, 3'b000});
        if (roll_off_reg == 7'd35)
        begin
            hdr_cfg.ro_code = RO_35;
        end
        else if (roll_off_reg == 7'd25)
        begin
            hdr_cfg.ro_code = RO_25;
        end
        else
        begin
            hdr_cfg.ro_code = RO_OTHER;
        end
    end

endmodule

FILE: rtl/core/bbf_front.sv
`timescale 1ns / 1ps

module bbf_front
    import bbf_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF,
    parameter int FB_W            = $clog2(MAX_FIELD_BYTES + 1),
    parameter int POS_W           = $clog2(MAX_FIELD_BYTES)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ts_valid,
    output logic            ts_ready,
    input  logic [7:0]      ts_byte,
    input  logic            busy,
    input  logic [FB_W-1:0] field_bytes,
    input  logic [FB_W-1:0] whole_bytes,
    input  logic            q_full,
    output logic            push,
    output entry_t          push_entry
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [FB_W:0]    pos_plus;
    logic             last;
    logic             in_whole;

    assign ts_ready = !q_full && !busy;
    assign push     = ts_valid && ts_ready;

    always_comb
    begin
        pos_plus = (FB_W + 1)'(pos_reg) + (FB_W + 1)'(1);
        last     = (pos_plus >= (FB_W + 1)'(field_bytes));
        in_whole = (FB_W'(pos_reg) < whole_bytes);
        pos_next = last ? '0 : POS_W'(pos_plus);

        push_entry.hdr  = (pos_reg == '0);
        push_entry.last = last;
        if (in_whole)
        begin
            push_entry.kind = KIND_DATA;
            push_entry.data = ts_byte;
        end
        else
        begin
            push_entry.kind = KIND_PAD;
            push_entry.data = PAD_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/bbf_queue.sv
`timescale 1ns / 1ps

module bbf_queue
    import bbf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t head
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/bbf_back.sv
`timescale 1ns / 1ps

module bbf_back
    import bbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  entry_t     head,
    input  hdr_cfg_t   hdr_cfg,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] byte_kind,
    output logic       frame_last
);

    logic [3:0] hdr_idx_reg;
    logic [7:0] crc_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] byte_kind_reg;
    logic       frame_last_reg;

    logic       advance;
    logic       hdr_phase;
    logic [7:0] crc_base;
    logic [7:0] hdr_byte;

    assign advance   = !empty && (!out_valid_reg || out_ready);
    assign hdr_phase = head.hdr && (hdr_idx_reg != HDR_DONE);
    assign pop       = advance && !hdr_phase;
    assign crc_base  = (hdr_idx_reg == HDR_MATYPE1) ? 8'd0 : crc_reg;

    always_comb
    begin
        unique case (hdr_idx_reg)
            HDR_MATYPE1: hdr_byte = {MATYPE_TS, 1'b1, hdr_cfg.adaptive, 2'b00, hdr_cfg.ro_code};
            HDR_MATYPE2: hdr_byte = hdr_cfg.stream_id;
            HDR_UPL_HI:  hdr_byte = UPL_BITS[15:8];
            HDR_UPL_LO:  hdr_byte = UPL_BITS[7:0];
            HDR_DFL_HI:  hdr_byte = hdr_cfg.dfl[15:8];
            HDR_DFL_LO:  hdr_byte = hdr_cfg.dfl[7:0];
            HDR_SYNC:    hdr_byte = SYNC_BYTE;
            HDR_SYNCD_H: hdr_byte = 8'd0;
            HDR_SYNCD_L: hdr_byte = 8'd0;
            HDR_CRC:     hdr_byte = crc_reg;
            default:     hdr_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg   <= HDR_MATYPE1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (hdr_phase)
                begin
                    hdr_idx_reg <= hdr_idx_reg + 4'd1;
                end
                else
                begin
                    hdr_idx_reg <= HDR_MATYPE1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output beat register and running crc over the header, one byte per beat
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (hdr_phase)
            begin
                crc_reg        <= crc8_update(crc_base, hdr_byte);
                out_byte_reg   <= hdr_byte;
                byte_kind_reg  <= KIND_HDR;
                frame_last_reg <= 1'b0;
            end
            else
            begin
                out_byte_reg   <= head.data;
                byte_kind_reg  <= head.kind;
                frame_last_reg <= head.last;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_kind  = byte_kind_reg;
    assign frame_last = frame_last_reg;

endmodule

FILE: rtl/core/dvbs2_baseband_framer_unit.sv
`timescale 1ns / 1ps

// dvb-s2 baseband framer: packs an mpeg transport stream into bbframes, byte wide
// input channel ts_valid/ts_ready/ts_byte takes one transport byte per beat
// output channel out_valid/out_ready carries out_byte, byte_kind and frame_last;
//   each frame is the 10-byte bbheader (kind header, crc-8 last) followed by
//   (kbch-80)/8 data field bytes: whole packets pass through, the remainder
//   of the field is consumed from the input and sent as 0xB8 pad bytes
// configuration: cfg_wr_en with cfg_index/cfg_data writes one register per cycle;
//   write only while the block is idle
// an input beat is held in the queue and then in the output register before it is offered at the output
// throughput: one byte per cycle through the data field while out_ready is high; the
//   header adds ten output beats per frame, during which the two-entry queue fills
//   and ts_ready drops
// after reset, and after any register write, ts_ready is low
//   while the frame length, packet count and dfl are recomputed
// when the receiver holds out_ready low the output register holds its beat,
//   the queue takes at most two more beats and ts_ready falls
module dvbs2_baseband_framer_unit
    import bbf_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        ts_valid,
    output logic        ts_ready,
    input  logic [7:0]  ts_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  byte_kind,
    output logic        frame_last
);

    localparam int FB_W  = $clog2(MAX_FIELD_BYTES + 1);
    localparam int POS_W = $clog2(MAX_FIELD_BYTES);

    logic            busy;
    logic [FB_W-1:0] field_bytes;
    logic [FB_W-1:0] whole_bytes;
    hdr_cfg_t        hdr_cfg;
    logic            push;
    entry_t          push_entry;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    entry_t          q_head;

    // registers and derived frame geometry
    bbf_cfg #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
        .FB_W            (FB_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .busy        (busy),
        .field_bytes (field_bytes),
        .whole_bytes (whole_bytes),
        .hdr_cfg     (hdr_cfg)
    );

    // front: tracks position in the data field, classifies data or pad
    bbf_front #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
        .FB_W            (FB_W),
        .POS_W           (POS_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ts_valid    (ts_valid),
        .ts_ready    (ts_ready),
        .ts_byte     (ts_byte),
        .busy        (busy),
        .field_bytes (field_bytes),
        .whole_bytes (whole_bytes),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decouples the front from header insertion and output stalls
    bbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    // back: inserts the header and crc ahead of the first field byte
    bbf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .head       (q_head),
        .hdr_cfg    (hdr_cfg),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_kind  (byte_kind),
        .frame_last (frame_last)
    );

endmodule

FILE: rtl/core/bbf_checker.sv
`timescale 1ns / 1ps

module bbf_checker
    import bbf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic        ts_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic [1:0]  byte_kind,
    input logic        frame_last
);

    // a stalled beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled beat keeps its byte
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("out_byte changed while stalled");

    // the frame never ends on a header byte
    a_last_not_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> byte_kind != KIND_HDR)
        else $error("frame_last on a header byte");

    // a register write holds off input while geometry is recomputed
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !ts_ready)
        else $error("input taken right after a register write");

    // a pad beat always carries the pad byte
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == KIND_PAD |-> out_byte == PAD_BYTE)
        else $error("pad beat without the pad byte");

endmodule

bind dvbs2_baseband_framer_unit bbf_checker u_bbf_checker (.*);
